FILE: src/spq_pkg.sv
// Package for the sorted priority queue: sizes, codes and the cell type.
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int PRIO_W   = 16;
    localparam int STAT_W   = 2;
    localparam int FILL_W   = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] data;
        logic        [PRIO_W-1:0] prio;
    } cell_t;

    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [DATA_W-1:0] data;
        logic        [PRIO_W-1:0] prio;
    } cell_ctrl_t;

endpackage

FILE: src/spq_cmd_if.sv
// Handshake channel carrying queue command items.
interface spq_cmd_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     op;
    logic signed [DATA_W-1:0] item_data;
    logic        [PRIO_W-1:0] item_priority;

    modport source (output valid, output op, output item_data, output item_priority,
                    input ready);
    modport sink   (input valid, input op, input item_data, input item_priority,
                    output ready);
endinterface

FILE: src/spq_rsp_if.sv
// Handshake channel carrying queue result items.
interface spq_rsp_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic        [STAT_W-1:0] status;
    logic signed [DATA_W-1:0] out_data;
    logic        [PRIO_W-1:0] out_priority;
    logic        [FILL_W-1:0] fill_level;

    modport source (output valid, output status, output out_data, output out_priority,
                    output fill_level, input ready);
    modport sink   (input valid, input status, input out_data, input out_priority,
                    input fill_level, output ready);
endinterface

FILE: src/sorted_priority_queue.sv
// Sorted priority queue built from a chain of shifting cells.
// Entries sit in a row of CAPACITY cells ordered by ascending priority; equal
// priorities leave in arrival order. Every cell compares its priority with the
// incoming one in parallel, so a new item is accepted every cycle while the
// result register can be emptied. The result of an item appears on rsp in the
// cycle after it is accepted. A remove on an empty queue reports status 1; an
// insert into a full queue is dropped and reports status 2. fill_level is the
// entry count after the item.
module sorted_priority_queue
    import spq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    spq_cmd_if.sink    cmd,
    spq_rsp_if.source  rsp
);

    cell_t      cells [CAPACITY];
    logic       after [CAPACITY];
    cell_ctrl_t ctrl;

    logic             acc;
    logic             is_full;
    logic             is_empty;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    status_t          status_next;

    logic                     out_valid_reg;
    status_t                  status_reg;
    logic signed [DATA_W-1:0] data_reg;
    logic        [PRIO_W-1:0] prio_reg;
    logic        [FILL_W-1:0] fill_reg;

    assign cmd.ready = !out_valid_reg || rsp.ready;
    assign acc       = cmd.valid && cmd.ready;
    assign is_full   = cells[CAPACITY-1].valid;
    assign is_empty  = !cells[0].valid;

    assign ctrl.ins  = acc && (cmd.op == OP_INSERT) && !is_full;
    assign ctrl.rem  = acc && (cmd.op == OP_REMOVE) && !is_empty;
    assign ctrl.data = cmd.item_data;
    assign ctrl.prio = cmd.item_priority;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        cell_t left_c;
        cell_t right_c;
        logic  left_a;

        if (i == 0)
        begin : g_first
            assign left_c = '0;
            assign left_a = 1'b0;
        end
        else
        begin : g_mid
            assign left_c = cells[i-1];
            assign left_a = after[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_c = '0;
        end
        else
        begin : g_inner
            assign right_c = cells[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .left       (left_c),
            .left_after (left_a),
            .right      (right_c),
            .cur        (cells[i]),
            .after      (after[i])
        );
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        status_next = ST_DONE;
        if (ctrl.ins)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (ctrl.rem)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        unique case (cmd.op)
            OP_INSERT: status_next = is_full  ? ST_FULL  : ST_DONE;
            OP_REMOVE: status_next = is_empty ? ST_EMPTY : ST_DONE;
            default:   status_next = ST_DONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (acc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            status_reg <= status_next;
            data_reg   <= ctrl.rem ? cells[0].data : '0;
            prio_reg   <= ctrl.rem ? cells[0].prio : '0;
            fill_reg   <= FILL_W'(cnt_next);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_data     = data_reg;
    assign rsp.out_priority = prio_reg;
    assign rsp.fill_level   = fill_reg;

`ifndef ASSERT_OFF
    logic [CAPACITY-1:0] valid_vec;

    always_comb
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            valid_vec[k] = cells[k].valid;
        end
    end

    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == CNT_W'($countones(valid_vec)))
        else $error("entry count differs from occupied cells");

    a_remove_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && cmd.op == OP_REMOVE && cnt_reg != '0) |=> cnt_reg == $past(cnt_reg) - CNT_W'(1))
        else $error("remove did not shrink the queue");

    a_full_status_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_FULL) |-> is_full)
        else $error("full status reported with free cells");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        cells[1].valid |-> (cells[0].valid && cells[0].prio <= cells[1].prio))
        else $error("head cells out of order");
`endif

endmodule

FILE: src/spq_cell.sv
// One storage cell of the sorted queue chain.
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  cell_t      left,
    input  logic       left_after,
    input  cell_t      right,
    output cell_t      cur,
    output logic       after
);

    logic                     valid_reg;
    logic signed [DATA_W-1:0] data_reg;
    logic        [PRIO_W-1:0] prio_reg;
    cell_t                    cell_next;

    // new entry belongs at or before this cell
    assign after = !valid_reg || (prio_reg > ctrl.prio);
    assign cur   = {valid_reg, data_reg, prio_reg};

    always_comb
    begin
        cell_next = cur;
        if (ctrl.rem)
        begin
            cell_next = right;
        end
        else if (ctrl.ins)
        begin
            if (left_after)
            begin
                cell_next = left;
            end
            else if (after)
            begin
                cell_next.valid = 1'b1;
                cell_next.data  = ctrl.data;
                cell_next.prio  = ctrl.prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cell_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= cell_next.data;
        prio_reg <= cell_next.prio;
    end

endmodule
